[rtl/qmc_pkg.sv]
//------------------------------------------------------------------------------
// qmc_pkg
// Shared types and constants for the quadratic max-convolution unit.
//------------------------------------------------------------------------------
package qmc_pkg;

    localparam int DATA_W  = 32;
    localparam int BOUND_W = 48;

    // Register indexes of the configuration port.
    localparam logic REG_WEIGHT = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MAXRD,
        ST_MAXCMP,
        ST_ENV_RD,
        ST_ENV_NUM,
        ST_ENV_DIV,
        ST_ENV_DEC,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_SQ,
        ST_OUT_W,
        ST_OUT_EMIT
    } qmc_state_t;

    // Divider request from the sequencer.
    typedef struct packed {
        logic               start;
        logic signed [79:0] num;
        logic signed [47:0] den;
    } qmc_div_req_t;

endpackage

[rtl/quadratic_max_convolution_1d_unit.sv]
//------------------------------------------------------------------------------
// quadratic_max_convolution_1d_unit
// Loads a score array, then streams its quadratic max-convolution.
//------------------------------------------------------------------------------
// Samples are taken one per cycle into a score memory until a transaction with
// tlast. The unit then builds the parabola envelope, about two steps per
// sample, each step reading memories and running a serial division. Each
// result then passes OUT_RD, OUT_MUL, OUT_SQ, OUT_W and OUT_EMIT; the scan
// repeats OUT_RD and OUT_MUL for each envelope entry it passes over, and an
// output handshake stall holds OUT_EMIT. No input is accepted while an array
// is being processed. With weight zero, a max search (MAXRD, MAXCMP per
// sample) replaces the envelope and each result takes only OUT_RD, OUT_MUL and
// OUT_EMIT. Results come ascending for weight zero or below, descending above.
// m_tdata: position[5:0], value[37:6], source[43:38], zeros;
// m_tlast marks the last result.
module quadratic_max_convolution_1d_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample[31:0]
    input  logic        s_tlast,   // final_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position[5:0], value[37:6], source[43:38]
    output logic        m_tlast    // done_res
);
    import qmc_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int BW = $clog2(MAX_LEN + 1);

    // Memories.
    logic signed [31:0] score_mem [MAX_LEN];
    logic [AW-1:0]      idx_mem   [MAX_LEN];
    logic signed [47:0] bnd_mem   [MAX_LEN+1];

    logic signed [31:0] weight_reg, offset_reg;
    qmc_state_t         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      q_reg, q_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      top_reg, top_next;
    logic [AW-1:0]      best_reg, best_next;
    logic signed [31:0] bestv_reg, bestv_next;
    logic [CW-1:0]      emitted_reg, emitted_next;

    // Memory read ports and data.
    logic [AW-1:0]      sa_addr, sb_addr, ix_addr;
    logic [BW-1:0]      bd_addr;
    logic signed [31:0] sa_q, sb_q;
    logic [AW-1:0]      ix_q;
    logic signed [47:0] bd_q;
    logic               sw_en, ix_we, bd_we;
    logic [AW-1:0]      sw_addr, ixw_addr;
    logic [BW-1:0]      bdw_addr;
    logic signed [31:0] sw_data;
    logic [AW-1:0]      ixw_data;
    logic signed [47:0] bdw_data;

    always_ff @(posedge clk)
    begin
        if (sw_en)
            score_mem[sw_addr] <= sw_data;
        if (ix_we)
            idx_mem[ixw_addr] <= ixw_data;
        if (bd_we)
            bnd_mem[bdw_addr] <= bdw_data;
        sa_q <= score_mem[sa_addr];
        sb_q <= score_mem[sb_addr];
        ix_q <= idx_mem[ix_addr];
        bd_q <= bnd_mem[bd_addr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT: weight_reg <= cfg_data;
                REG_OFFSET: offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Divider.
    qmc_div_req_t       div_req;
    logic               div_busy;
    logic signed [79:0] div_quot;

    qmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Datapath registers for the envelope step and the evaluation.
    logic signed [47:0] sv_reg, sv_next;      // candidate boundary
    logic signed [47:0] t_reg, t_next;
    logic [47:0]        sq_hi_reg, sq_lo_reg;
    logic [31:0]        aw;
    logic signed [31:0] fp_reg, fp_next;
    logic [AW-1:0]      src_reg, src_next;
    logic signed [31:0] val_reg, val_next;
    logic [AW-1:0]      os_reg, os_next;      // source of the held result
    logic signed [31:0] ov_reg, ov_next;      // value of the held result
    logic               last_reg, last_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               mv_reg, mv_next;
    logic               neg;
    logic signed [13:0] qq, vv;
    logic signed [79:0] num_c;
    logic signed [47:0] den_c;
    logic signed [81:0] s_full;
    logic signed [47:0] s_sat;
    logic [AW-1:0]      v_cur;
    logic [32:0]        at;
    logic [65:0]        sq_full;
    logic [63:0]        m_hi, m_lo;
    logic [66:0]        m_sum;
    logic signed [35:0] m_sat;
    logic signed [36:0] r_sum;
    logic signed [47:0] qfix;
    logic               adv;

    assign neg = weight_reg[31];
    assign aw  = neg ? 32'(-weight_reg) : 32'(weight_reg);

    // Boundary numerator and denominator from the two scores.
    always_comb
    begin
        qq    = 14'(q_reg) * 14'(q_reg);
        vv    = 14'({1'b0, v_cur}) * 14'({1'b0, v_cur});
        num_c = 80'(((48'(sa_q) - 48'(sb_q)) + 48'(weight_reg) * 48'(qq - vv))) <<< 16;
        den_c = 48'(2) * 48'(weight_reg) * 48'($signed({1'b0, q_reg}) - $signed({1'b0, v_cur}));
        s_full = 82'(div_quot) + 82'(offset_reg);
        if (s_full > 82'sh7FFFFFFFFFFF)
            s_sat = 48'sh7FFFFFFFFFFF;
        else if (s_full < -82'sh800000000000)
            s_sat = -48'sh800000000000;
        else
            s_sat = s_full[47:0];
    end

    // Squared-term magnitude of the evaluation; |t| stays below 2^33.
    always_comb
    begin
        at    = t_reg[47] ? 33'(-t_reg) : 33'(t_reg);
        sq_full = 66'(at) * 66'(at);
        m_hi  = 64'(aw) * 64'(sq_hi_reg[31:0]);
        m_lo  = 64'(aw) * 64'(sq_lo_reg[31:0]);
        m_sum = 67'(m_hi) + 67'(m_lo[63:32]);
        if (sq_hi_reg[47:32] != '0 || m_sum > 67'h400000000)
            m_sat = 36'sh400000000;
        else
            m_sat = 36'(m_sum);
        r_sum = neg ? 37'(fp_reg) - 37'(m_sat) : 37'(fp_reg) + 37'(m_sat);
        qfix  = 48'(q_reg) <<< 16;
    end

    assign v_cur = ix_q;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        q_next       = q_reg;
        k_next       = k_reg;
        top_next     = top_reg;
        best_next    = best_reg;
        bestv_next   = bestv_reg;
        emitted_next = emitted_reg;
        sv_next      = sv_reg;
        t_next       = t_reg;
        fp_next      = fp_reg;
        src_next     = src_reg;
        val_next     = val_reg;
        os_next      = os_reg;
        ov_next      = ov_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        mv_next      = mv_reg && !m_tready;
        sw_en        = 1'b0;
        sw_addr      = cnt_reg[AW-1:0];
        sw_data      = s_tdata;
        ix_we        = 1'b0;
        ixw_addr     = k_reg;
        ixw_data     = '0;
        bd_we        = 1'b0;
        bdw_addr     = BW'(k_reg);
        bdw_data     = sv_reg;
        sa_addr      = q_reg[AW-1:0];
        sb_addr      = ix_q;
        ix_addr      = k_reg;
        bd_addr      = BW'(k_reg);
        div_req      = '0;
        s_tready     = 1'b0;
        adv          = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    sw_en = (cnt_reg < CW'(MAX_LEN));
                    cnt_next = sw_en ? cnt_reg + CW'(1) : cnt_reg;
                    if (s_tlast)
                    begin
                        n_next       = cnt_next;
                        cnt_next     = '0;
                        emitted_next = '0;
                        q_next       = '0;
                        k_next       = '0;
                        best_next    = '0;
                        if (weight_reg == '0)
                            state_next = ST_MAXRD;
                        else
                        begin
                            ix_we      = 1'b1;
                            ixw_addr   = '0;
                            q_next     = CW'(1);
                            state_next = ST_ENV_RD;
                        end
                    end
                end
            end
            // Max search: read a score, compare on the next cycle.
            ST_MAXRD:
            begin
                sa_addr    = q_reg[AW-1:0];
                state_next = ST_MAXCMP;
            end
            ST_MAXCMP:
            begin
                if (q_reg == '0 || sa_q > bestv_reg)
                begin
                    bestv_next = sa_q;
                    best_next  = q_reg[AW-1:0];
                end
                if (q_reg + CW'(1) >= n_reg)
                begin
                    q_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    q_next     = q_reg + CW'(1);
                    state_next = ST_MAXRD;
                end
            end
            // Envelope: read idx[k], bound[k]; then scores; divide; decide.
            ST_ENV_RD:
            begin
                if (q_reg >= n_reg)
                begin
                    top_next   = k_reg;
                    k_next     = '0;
                    q_next     = neg ? '0 : n_reg - CW'(1);
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    ix_addr    = k_reg;
                    bd_addr    = BW'(k_reg);
                    state_next = ST_ENV_NUM;
                end
            end
            ST_ENV_NUM:
            begin
                sa_addr    = q_reg[AW-1:0];
                sb_addr    = v_cur;
                ix_addr    = k_reg;
                bd_addr    = BW'(k_reg);
                state_next = ST_ENV_DIV;
            end
            ST_ENV_DIV:
            begin
                ix_addr       = k_reg;
                bd_addr       = BW'(k_reg);
                div_req.start = 1'b1;
                div_req.num   = num_c;
                div_req.den   = den_c;
                state_next    = ST_ENV_DEC;
            end
            ST_ENV_DEC:
            begin
                ix_addr = k_reg;
                bd_addr = BW'(k_reg);
                if (!div_busy && !div_req.start)
                begin
                    sv_next = s_sat;
                    if (k_reg != '0 && (neg ? s_sat <= bd_q : s_sat >= bd_q))
                        k_next = k_reg - AW'(1);
                    else
                    begin
                        k_next   = k_reg + AW'(1);
                        ix_we    = 1'b1;
                        ixw_addr = k_reg + AW'(1);
                        ixw_data = q_reg[AW-1:0];
                        bd_we    = 1'b1;
                        bdw_addr = BW'(k_reg) + BW'(1);
                        bdw_data = s_sat;
                        q_next   = q_reg + CW'(1);
                    end
                    state_next = ST_ENV_RD;
                end
            end
            // Output: scan to the right envelope entry, then evaluate; with weight zero, take the maximum found.
            ST_OUT_RD:
            begin
                ix_addr    = k_reg;
                bd_addr    = BW'(k_reg) + BW'(1);
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                if (weight_reg == '0)
                begin
                    src_next   = best_reg;
                    val_next   = bestv_reg;
                    state_next = ST_OUT_EMIT;
                end
                else if (k_reg < top_reg && (neg ? bd_q < qfix : bd_q > qfix))
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    sa_addr    = ix_q;
                    src_next   = ix_q;
                    t_next     = ((48'(q_reg) - 48'(ix_q)) <<< 16) - 48'(offset_reg);
                    state_next = ST_OUT_SQ;
                end
            end
            ST_OUT_SQ:
            begin
                fp_next    = sa_q;
                state_next = ST_OUT_W;
            end
            ST_OUT_W:
            begin
                adv = 1'b1;
                if (r_sum > 37'sh7FFFFFFF)
                    val_next = 32'sh7FFFFFFF;
                else if (r_sum < -37'sh80000000)
                    val_next = -32'sh80000000;
                else
                    val_next = r_sum[31:0];
                state_next = ST_OUT_EMIT;
            end
            // Move the finished result into the output holding registers.
            ST_OUT_EMIT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next      = 1'b1;
                    pos_next     = q_reg;
                    os_next      = src_reg;
                    ov_next      = val_reg;
                    last_next    = (emitted_reg + CW'(1) == n_reg);
                    emitted_next = emitted_reg + CW'(1);
                    if (emitted_reg + CW'(1) == n_reg)
                        state_next = ST_LOAD;
                    else
                    begin
                        q_next     = (neg || weight_reg == '0) ? q_reg + CW'(1)
                                                               : q_reg - CW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Square of t, split into registered halves before the weight multiply.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT_SQ)
        begin
            sq_hi_reg <= 48'(sq_full[65:32]);
            sq_lo_reg <= {16'd0, sq_full[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            mv_reg      <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mv_reg      <= mv_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        top_reg   <= top_next;
        best_reg  <= best_next;
        bestv_reg <= bestv_next;
        sv_reg    <= sv_next;
        t_reg     <= t_next;
        fp_reg    <= fp_next;
        src_reg   <= src_next;
        val_reg   <= val_next;
        os_reg    <= os_next;
        ov_reg    <= ov_next;
        last_reg  <= last_next;
        pos_reg   <= pos_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'd0, 6'(os_reg), ov_reg, 6'(pos_reg)};

    // Checks.
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_tready)
        else $error("input accepted while processing");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_LEN))
        else $error("fill count overflow");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (state_reg == ST_OUT_EMIT))
        else $error("evaluation did not reach emit");

endmodule

[rtl/qmc_div.sv]
//------------------------------------------------------------------------------
// qmc_div
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
//------------------------------------------------------------------------------
module qmc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qmc_pkg::qmc_div_req_t req,
    output logic                 busy,
    output logic signed [79:0]   quot
);
    import qmc_pkg::*;

    logic [79:0] q_reg, q_next;
    logic [47:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] trial;

    // One shift-subtract step per cycle over the magnitudes.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[79]} - {1'b0, d_reg};
        if (req.start)
        begin
            q_next    = req.num[79] ? 80'(-req.num) : 80'(req.num);
            d_next    = req.den[47] ? 48'(-req.den) : 48'(req.den);
            r_next    = '0;
            neg_next  = req.num[79] ^ req.den[47];
            cnt_next  = 7'd80;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[48])
            begin
                r_next = trial[47:0];
                q_next = {q_reg[78:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[46:0], q_reg[79]};
                q_next = {q_reg[78:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
